>>> design/kffc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kffc_pkg
// Shared codes, limits and handshake types of the keypad calculator.
// ----------------------------------------------------------------------------
package kffc_pkg;

  // key codes, also used as the pending operation code
  localparam logic [2:0] KEY_DIGIT  = 3'd0;
  localparam logic [2:0] KEY_ADD    = 3'd1;
  localparam logic [2:0] KEY_SUB    = 3'd2;
  localparam logic [2:0] KEY_MUL    = 3'd3;
  localparam logic [2:0] KEY_DIV    = 3'd4;
  localparam logic [2:0] KEY_EQUALS = 3'd5;
  localparam logic [2:0] KEY_CLEAR  = 3'd6;

  // no operation waiting for its second operand
  localparam logic [2:0] OP_NONE = 3'd0;

  // entry and result limits
  localparam logic signed [31:0] ENTRY_LIMIT     = 32'sd100000000;
  localparam logic [63:0]        RESULT_HIGH_MAG = 64'd999999999;
  localparam logic [63:0]        RESULT_LOW_MAG  = 64'd99999999;
  localparam logic [3:0]         DIGIT_MAX       = 4'd9;

  // iterative unit sizing: one bit of multiplier or quotient per step
  localparam int ARITH_STEPS = 32;
  localparam int STEP_W      = $clog2(ARITH_STEPS);

  typedef enum logic [1:0] {
    ARITH_ADD,
    ARITH_SUB,
    ARITH_MUL,
    ARITH_DIV
  } arith_op_t;

  typedef enum logic [1:0] {
    AU_IDLE,
    AU_RUN,
    AU_DONE
  } arith_state_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FINISH
  } ctl_state_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  typedef struct packed {
    logic        done;
    logic        neg;
    logic [63:0] mag;
  } arith_rsp_t;

endpackage

>>> design/kffc_arith.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kffc_arith
// Shared 33-bit adder under a small sequencer: add and subtract in one pass,
// multiply by shift and add, divide by restoring subtraction, 32 steps each.
// Result comes back as a sign and a 64-bit magnitude.
// ----------------------------------------------------------------------------
module kffc_arith (
  input  logic                 clk,
  input  logic                 rst,
  input  kffc_pkg::arith_req_t req,
  input  logic signed [31:0]   a,
  input  logic signed [31:0]   b,
  output kffc_pkg::arith_rsp_t rsp
);
  import kffc_pkg::*;

  arith_state_t      state;
  arith_state_t      state_next;
  arith_op_t         op_q;
  logic              neg_q;
  logic [31:0]       am;
  logic [31:0]       bm;
  logic [64:0]       work;
  logic [STEP_W-1:0] count;

  logic [31:0] a_mag;
  logic [31:0] b_mag;
  logic [32:0] add_x;
  logic [32:0] add_y;
  logic        add_sub;
  logic [32:0] add_sum;
  logic [32:0] sum_s;

  // operand magnitudes
  assign a_mag = a[31] ? (~a + 32'd1) : a;
  assign b_mag = b[31] ? (~b + 32'd1) : b;

  // operand selection for the shared adder
  always_comb begin
    add_x   = {a[31], a};
    add_y   = {b[31], b};
    add_sub = (req.op == ARITH_SUB);
    if (state == AU_RUN) begin
      case (op_q)
        ARITH_MUL: begin
          add_x   = {1'b0, work[63:32]};
          add_y   = work[0] ? {1'b0, am} : 33'd0;
          add_sub = 1'b0;
        end
        ARITH_DIV: begin
          add_x   = {work[63:32], work[31]};
          add_y   = {1'b0, bm};
          add_sub = 1'b1;
        end
        default: begin
          add_sub = (op_q == ARITH_SUB);
        end
      endcase
    end
  end

  // the one adder
  assign add_sum = add_x + (add_sub ? ~add_y : add_y) + {32'd0, add_sub};

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      AU_IDLE: begin
        if (req.start) begin
          if (req.op == ARITH_MUL || req.op == ARITH_DIV) begin
            state_next = AU_RUN;
          end else begin
            state_next = AU_DONE;
          end
        end
      end
      AU_RUN: begin
        if (count == STEP_W'(ARITH_STEPS - 1)) begin
          state_next = AU_DONE;
        end
      end
      AU_DONE: begin
        state_next = AU_IDLE;
      end
      default: begin
        state_next = AU_IDLE;
      end
    endcase
  end

  // result formatting
  assign sum_s = work[32:0];

  always_comb begin
    rsp.done = (state == AU_DONE);
    case (op_q)
      ARITH_MUL: begin
        rsp.neg = neg_q;
        rsp.mag = work[63:0];
      end
      ARITH_DIV: begin
        rsp.neg = neg_q;
        rsp.mag = {32'd0, work[31:0]};
      end
      default: begin
        rsp.neg = sum_s[32];
        rsp.mag = {31'd0, (sum_s[32] ? (~sum_s + 33'd1) : sum_s)};
      end
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= AU_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // working register and step count
  always_ff @(posedge clk) begin
    if (state == AU_IDLE && req.start) begin
      op_q  <= req.op;
      am    <= a_mag;
      bm    <= b_mag;
      neg_q <= a[31] ^ b[31];
      count <= '0;
      case (req.op)
        ARITH_MUL: work <= {33'd0, b_mag};
        ARITH_DIV: work <= {33'd0, a_mag};
        default:   work <= {{32{add_sum[32]}}, add_sum};
      endcase
    end else if (state == AU_RUN) begin
      count <= count + STEP_W'(1);
      case (op_q)
        ARITH_MUL: work <= {1'b0, add_sum, work[31:1]};
        ARITH_DIV: begin
          work <= {(add_sum[32] ? {work[63:32], work[31]} : add_sum),
                   work[30:0], ~add_sum[32]};
        end
        default: work <= work;
      endcase
    end
  end

endmodule

>>> design/keypad_four_function_calculator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_four_function_calculator_unit
// Four-function calculator taking one key per transaction. A digit or clear
// goes from acceptance to the finish state and on into the output register,
// as does an operator or equals that meets a pending divide by zero. An
// operator or equals with any other operation pending goes through the calc
// state first while the shared adder in kffc_arith does the operation, taking
// its 32 steps for multiply and divide. An operator with nothing
// pending, equals with nothing pending and the unused key code give no result
// and the block is ready again in the next cycle. The input stalls while a
// key is being worked on and while a finished result waits for the output
// register to free up; the next key is taken in the cycle after the result
// is loaded.
// ----------------------------------------------------------------------------
module keypad_four_function_calculator_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         kind,
  input  logic [3:0]         digit,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [30:0] display_value,
  output logic               error
);
  import kffc_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;

  // calculator state, held as 32-bit words
  logic signed [31:0] entry;
  logic signed [31:0] first;
  logic [2:0]         pending;
  logic               entry_open;

  logic [2:0]         key_q;
  logic signed [31:0] res_value;
  logic               res_err;

  logic               accept;
  logic               out_load;
  logic               pend_live;
  logic               div_zero;
  logic [3:0]         digit_sat;
  logic signed [31:0] base;
  logic signed [31:0] grown;
  logic signed [31:0] digit_val;
  logic               in_range;
  logic signed [31:0] calc_val;
  logic               key_is_op;

  arith_req_t arith_req;
  arith_rsp_t arith_rsp;

  kffc_arith u_arith (
    .clk (clk),
    .rst (rst),
    .req (arith_req),
    .a   (first),
    .b   (entry),
    .rsp (arith_rsp)
  );

  // key decode helpers
  assign accept    = in_valid && !in_stall;
  assign pend_live = (pending == KEY_ADD) || (pending == KEY_SUB) ||
                     (pending == KEY_MUL) || (pending == KEY_DIV);
  assign div_zero  = (pending == KEY_DIV) && (entry == 32'sd0);
  assign key_is_op = (key_q == KEY_ADD) || (key_q == KEY_SUB) ||
                     (key_q == KEY_MUL) || (key_q == KEY_DIV);

  // digit append: entry times ten plus the digit, digits above nine taken as nine, a full entry kept
  assign digit_sat = (digit > DIGIT_MAX) ? DIGIT_MAX : digit;
  assign base      = entry_open ? entry : 32'sd0;
  assign grown     = (base <<< 3) + (base <<< 1) + {28'd0, digit_sat};
  assign digit_val = (base < ENTRY_LIMIT) ? grown : base;

  // range check and signed value of the unit's result
  assign in_range = arith_rsp.neg ? (arith_rsp.mag <= RESULT_LOW_MAG)
                                  : (arith_rsp.mag <= RESULT_HIGH_MAG);
  assign calc_val = arith_rsp.neg ? (~arith_rsp.mag[31:0] + 32'd1)
                                  : arith_rsp.mag[31:0];

  // control next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (kind) inside
            KEY_DIGIT, KEY_CLEAR: state_next = ST_FINISH;
            KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV, KEY_EQUALS: begin
              if (pend_live) begin
                state_next = div_zero ? ST_FINISH : ST_CALC;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_CALC: begin
        if (arith_rsp.done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    in_stall        = (state != ST_IDLE);
    out_load        = (state == ST_FINISH) && (!out_valid || !out_stall);
    arith_req.start = 1'b0;
    if (state == ST_IDLE && in_valid && pend_live && !div_zero) begin
      case (kind) inside
        KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV, KEY_EQUALS: arith_req.start = 1'b1;
        default: arith_req.start = 1'b0;
      endcase
    end
    case (pending)
      KEY_SUB: arith_req.op = ARITH_SUB;
      KEY_MUL: arith_req.op = ARITH_MUL;
      KEY_DIV: arith_req.op = ARITH_DIV;
      default: arith_req.op = ARITH_ADD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // calculator state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      entry      <= 32'sd0;
      first      <= 32'sd0;
      pending    <= OP_NONE;
      entry_open <= 1'b1;
    end else if (accept) begin
      case (kind) inside
        KEY_DIGIT: begin
          entry      <= digit_val;
          entry_open <= 1'b1;
        end
        KEY_CLEAR: begin
          entry   <= 32'sd0;
          first   <= 32'sd0;
          pending <= OP_NONE;
        end
        KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV: begin
          if (!pend_live) begin
            pending <= kind;
            first   <= entry;
            entry   <= 32'sd0;
          end else if (div_zero) begin
            pending <= kind;
            first   <= 32'sd0;
            entry   <= 32'sd0;
          end
        end
        KEY_EQUALS: begin
          if (pend_live && div_zero) begin
            pending <= OP_NONE;
            first   <= 32'sd0;
            entry   <= 32'sd0;
          end
        end
        default: begin
          entry <= entry;
        end
      endcase
    end else if (state == ST_CALC && arith_rsp.done) begin
      entry_open <= 1'b0;
      if (key_is_op) begin
        pending <= key_q;
        first   <= in_range ? calc_val : 32'sd0;
        entry   <= 32'sd0;
      end else begin
        pending <= OP_NONE;
        first   <= 32'sd0;
        entry   <= in_range ? calc_val : 32'sd0;
      end
    end
  end

  // result staging
  always_ff @(posedge clk) begin
    if (accept) begin
      key_q <= kind;
      case (kind) inside
        KEY_DIGIT: begin
          res_value <= digit_val;
          res_err   <= 1'b0;
        end
        KEY_CLEAR: begin
          res_value <= 32'sd0;
          res_err   <= 1'b0;
        end
        default: begin
          res_value <= 32'sd0;
          res_err   <= 1'b1;
        end
      endcase
    end else if (state == ST_CALC && arith_rsp.done) begin
      res_value <= in_range ? calc_val : 32'sd0;
      res_err   <= !in_range;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      display_value <= res_value[30:0];
      error         <= res_err;
    end
  end

`ifndef SYNTHESIS
  a_done_in_calc: assert property (@(posedge clk) disable iff (rst)
    arith_rsp.done |-> state == ST_CALC)
    else $error("arithmetic unit finished outside the calc state");

  a_err_shows_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error) |-> display_value == 31'sd0)
    else $error("error result with a non-zero display value");

  a_result_closes_entry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CALC && arith_rsp.done) |=> !entry_open)
    else $error("entry still open after an arithmetic result");

  a_start_enters_calc: assert property (@(posedge clk) disable iff (rst)
    arith_req.start |=> state == ST_CALC)
    else $error("arithmetic start without entering the calc state");

  a_pending_code: assert property (@(posedge clk) disable iff (rst)
    pending == OP_NONE || pending == KEY_ADD || pending == KEY_SUB ||
    pending == KEY_MUL || pending == KEY_DIV)
    else $error("pending operation holds a key code that is no operator");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keypad calculator. Key presses go in from a
// queue, each accepted key is run through a local calculator model, and
// every shown value is checked against the oldest outstanding one under
// four patterns of sender idling and receiver stall.
// ----------------------------------------------------------------------------
module tb;
  import kffc_pkg::*;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] digit;
  } key_t;

  typedef struct packed {
    logic signed [30:0] value;
    logic               err;
  } shown_t;

  // key code the block ignores
  localparam logic [2:0] KEY_UNUSED = 3'd7;

  localparam longint SHOWN_HIGH   = 64'sd999999999;
  localparam longint SHOWN_LOW    = -64'sd99999999;
  localparam longint ENTRY_FULL   = 64'sd100000000;
  localparam int     PHASE_KEYS   = 250;
  localparam int     NUM_PHASES   = 4;
  localparam int     SETTLE_WAIT  = 60;
  localparam int     PRINT_CAP    = 100;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [2:0]         kind      = KEY_DIGIT;
  logic [3:0]         digit     = 4'd0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [30:0] display_value;
  logic               error;

  // pending key presses and shown values still owed by the block
  key_t   key_queue[$];
  shown_t shown_queue[$];

  // local copy of the calculator state
  logic signed [30:0] calc_entry;
  logic signed [30:0] calc_first;
  logic [2:0]         calc_pending;
  logic               calc_open;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int keys_queued   = 0;
  int keys_accepted = 0;
  int shown_checked = 0;
  int err_shown     = 0;
  int mismatches    = 0;
  shown_t want;

  keypad_four_function_calculator_unit dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .digit         (digit),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .display_value (display_value),
    .error         (error)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // calculator model
  // ------------------------------------------------------------------

  task automatic report_mismatch(string what);
    mismatches++;
    // keep the log short if the block is badly broken
    if (mismatches <= PRINT_CAP)
      $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic owe_shown(logic signed [30:0] value, logic err);
    shown_t s;
    s.value = value;
    s.err   = err;
    shown_queue.push_back(s);
  endtask

  // completes any waiting operation, owing a shown value if one was waiting
  task automatic complete_operation();
    longint lhs = calc_first;
    longint rhs = calc_entry;
    longint res;
    if (calc_pending == KEY_DIV && rhs == 0) begin
      // divide by zero: operands dropped, entry state kept
      calc_entry   = '0;
      calc_first   = '0;
      calc_pending = OP_NONE;
      owe_shown('0, 1'b1);
      return;
    end
    case (calc_pending)
      KEY_ADD: res = lhs + rhs;
      KEY_SUB: res = lhs - rhs;
      KEY_MUL: res = lhs * rhs;
      KEY_DIV: res = lhs / rhs;
      default: return;
    endcase
    calc_first   = '0;
    calc_pending = OP_NONE;
    calc_open    = 1'b0;
    if (res > SHOWN_HIGH || res < SHOWN_LOW) begin
      calc_entry = '0;
      owe_shown('0, 1'b1);
    end else begin
      calc_entry = res[30:0];
      owe_shown(calc_entry, 1'b0);
    end
  endtask

  task automatic apply_key(key_t k);
    logic [3:0] d;
    d = (k.digit > DIGIT_MAX) ? DIGIT_MAX : k.digit;
    keys_accepted++;
    case (k.kind)
      KEY_DIGIT: begin
        if (!calc_open) begin
          calc_entry = '0;
          calc_open  = 1'b1;
        end
        // a full entry stays as it is
        if (calc_entry < ENTRY_FULL)
          calc_entry = 31'(longint'(calc_entry) * 10 + longint'(d));
        owe_shown(calc_entry, 1'b0);
      end
      KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV: begin
        complete_operation();
        calc_pending = k.kind;
        calc_first   = calc_entry;
        calc_entry   = '0;
      end
      KEY_EQUALS: begin
        complete_operation();
      end
      KEY_CLEAR: begin
        calc_entry   = '0;
        calc_first   = '0;
        calc_pending = OP_NONE;
        owe_shown('0, 1'b0);
      end
      default: ;
    endcase
  endtask

  // ------------------------------------------------------------------
  // key driver: one transaction per accepted key
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      calc_entry   = '0;
      calc_first   = '0;
      calc_pending = OP_NONE;
      calc_open    = 1'b1;
    end else begin
      if (in_valid && !in_stall)
        apply_key('{kind: kind, digit: digit});
      // payload only moves once the current key is gone
      if (!in_valid || !in_stall) begin
        if (key_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          kind     <= key_queue[0].kind;
          digit    <= key_queue[0].digit;
          key_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // result monitor
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
      if (out_valid && !out_stall) begin
        if (shown_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d err %0b", display_value, error));
        end else begin
          want = shown_queue.pop_front();
          shown_checked++;
          if (want.err)
            err_shown++;
          if (error !== want.err)
            report_mismatch($sformatf("error %b, expected %b", error, want.err));
          if (display_value !== want.value)
            report_mismatch($sformatf("display_value %0d, expected %0d",
                                      display_value, want.value));
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // stimulus
  // ------------------------------------------------------------------

  task automatic add_key(logic [2:0] k, logic [3:0] d);
    key_t item;
    item.kind  = k;
    item.digit = d;
    key_queue.push_back(item);
    if (k != KEY_UNUSED)
      keys_queued++;
  endtask

  // a number of mostly short length, now and then a zero or a long one
  task automatic add_number();
    int len;
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      add_key(KEY_DIGIT, 4'd0);
      return;
    end
    if (pick < 80)
      len = $urandom_range(3, 1);
    else if (pick < 95)
      len = $urandom_range(6, 4);
    else
      len = $urandom_range(11, 7);
    repeat (len) begin
      if ($urandom_range(15) == 0)
        add_key(KEY_DIGIT, 4'($urandom_range(15)));
      else
        add_key(KEY_DIGIT, 4'($urandom_range(9)));
    end
  endtask

  task automatic add_random_sequence();
    int pick;
    int ops;
    pick = $urandom_range(99);
    if (pick < 72) begin
      // calculation of one to three operators, now and then missing a number
      add_number();
      ops = $urandom_range(3, 1);
      repeat (ops) begin
        add_key(3'($urandom_range(KEY_DIV, KEY_ADD)), 4'($urandom_range(15)));
        if ($urandom_range(9) != 0)
          add_number();
      end
      if ($urandom_range(3) != 0)
        add_key(KEY_EQUALS, 4'($urandom_range(15)));
    end else if (pick < 80) begin
      add_key(KEY_CLEAR, 4'($urandom_range(15)));
    end else begin
      // noise: any key code with any digit
      repeat ($urandom_range(4, 1))
        add_key(3'($urandom_range(7)), 4'($urandom_range(15)));
    end
  endtask

  // let the sender run dry, every owed result come back and the block settle
  task automatic wait_drained();
    do
      @(negedge clk);
    while (key_queue.size() != 0 || in_valid || shown_queue.size() != 0);
    repeat (SETTLE_WAIT) @(negedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: ignored keys, full entry with saturating digit, overflow,
    // divide by zero, subtract, chained add
    add_key(KEY_EQUALS, 4'd0);
    add_key(KEY_UNUSED, 4'd15);
    repeat (10) add_key(KEY_DIGIT, 4'd15);
    add_key(KEY_MUL, 4'd0);
    add_key(KEY_DIGIT, 4'd9);
    add_key(KEY_EQUALS, 4'd0);
    add_key(KEY_DIGIT, 4'd0);
    add_key(KEY_DIV, 4'd0);
    add_key(KEY_DIGIT, 4'd0);
    add_key(KEY_EQUALS, 4'd0);
    add_key(KEY_DIGIT, 4'd5);
    add_key(KEY_SUB, 4'd0);
    add_key(KEY_DIGIT, 4'd7);
    add_key(KEY_ADD, 4'd0);
    add_key(KEY_DIGIT, 4'd3);
    add_key(KEY_EQUALS, 4'd0);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 66; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 66; end
        default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
      while (keys_queued < (phase + 1) * PHASE_KEYS)
        add_random_sequence();
      wait_drained();
    end

    $display("covered %0d keys over %0d idling patterns, %0d results checked (%0d Err)",
             keys_accepted, NUM_PHASES, shown_checked, err_shown);
    $display("mismatches found: %0d", mismatches);
    if (mismatches == 0 && shown_queue.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // run limit
  initial begin
    #(2_000_000);
    $display("timeout with %0d results outstanding", shown_queue.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> files.f
design/kffc_pkg.sv
design/kffc_arith.sv
design/keypad_four_function_calculator_unit.sv
tb/tb.sv
